// ===== rtl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debounce and long-press logic.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;

	localparam logic [CFG_W-1:0] DEFAULT_DEBOUNCE = 16'd20;
	localparam logic [CFG_W-1:0] DEFAULT_HOLD     = 16'd3000;

	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_HOLD     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] settle_len;
		logic [CFG_W-1:0] hold_ms;
	} timing_t;

	typedef struct packed {
		logic              pressed;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

endpackage

// ===== rtl/button_debounce_long_press_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounces raw button samples and flags a long press once per press.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         pressed, now_ms (one timestamped sample per item)
//  m_axis    out        long_press (one result per sample)
//  cfg       in         debounce_time (index 0), hold_time (index 1)
//
// Each item passes an input register and a result register, and one item is
// taken every cycle while the result is not stalled. The state update is a
// pair of 32-bit subtract and compare paths in parallel. Reset clears the
// valid flags and the evaluation state and selects the default times.
// A stalled result holds the pipeline; with both registers full, s_tready
// follows m_tready.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pressed, now_ms, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // long_press, zero fill
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import bdlp_pkg::*;

	timing_t timing;
	sample_t sample_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    long_press_q;
	logic    advance;
	logic    pulse;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1.pressed <= s_tdata[0];
			sample_s1.now_ms  <= s_tdata[32:1];
		end
	end

	bdlp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.timing (timing)
	);

	bdlp_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.timing (timing),
		.pulse  (pulse)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			long_press_q <= pulse;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, long_press_q};

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stage refused an item while empty");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pulse ##1 advance |-> !pulse)
		else $error("long press flagged on two consecutive samples");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && (long_press_q == $past(pulse)))
		else $error("result register lost an evaluated sample");
`endif

endmodule

// ===== rtl/bdlp_cfg.sv =====
// ----------------------------------------------------------------------------
// bdlp_cfg
// Timing registers with substitution of the default for a zero setting.
// ----------------------------------------------------------------------------
module bdlp_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic                    addr,
	input  logic [15:0]             wdata,
	output bdlp_pkg::timing_t       timing
);
	import bdlp_pkg::*;

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			hold_q     <= '0;
		end else if (we) begin
			unique case (reg_idx_t'(addr))
				REG_DEBOUNCE: debounce_q <= wdata;
				REG_HOLD:     hold_q     <= wdata;
				default:      ;
			endcase
		end
	end

	assign timing.settle_len = (debounce_q == '0) ? DEFAULT_DEBOUNCE : debounce_q;
	assign timing.hold_ms    = (hold_q == '0) ? DEFAULT_HOLD : hold_q;

endmodule

// ===== rtl/bdlp_eval.sv =====
// ----------------------------------------------------------------------------
// bdlp_eval
// Debounce and press tracking state; evaluates one sample per step.
// ----------------------------------------------------------------------------
module bdlp_eval (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  bdlp_pkg::sample_t       sample,
	input  bdlp_pkg::timing_t       timing,
	output logic                    pulse
);
	import bdlp_pkg::*;

	logic              last_raw_q;
	logic [TIME_W-1:0] change_time_q;
	logic              stable_q;
	logic              fired_q;
	logic [TIME_W-1:0] press_start_q;

	logic              raw_same;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_press;
	logic              settled;
	logic              held;

	// A raw change restarts the debounce window, so a sample can only settle
	// when it matches the previous raw level.
	assign raw_same     = (sample.pressed == last_raw_q);
	assign since_change = sample.now_ms - change_time_q;
	assign since_press  = sample.now_ms - press_start_q;
	assign settled      = raw_same &&
		(since_change >= {{(TIME_W-CFG_W){1'b0}}, timing.settle_len});
	assign held         = since_press >= {{(TIME_W-CFG_W){1'b0}}, timing.hold_ms};
	assign pulse        = settled && stable_q && sample.pressed && !fired_q && held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			change_time_q <= '0;
			stable_q      <= 1'b0;
			fired_q       <= 1'b0;
			press_start_q <= '0;
		end else if (step) begin
			if (!raw_same) begin
				last_raw_q    <= sample.pressed;
				change_time_q <= sample.now_ms;
			end
			if (settled) begin
				if (stable_q != sample.pressed) begin
					stable_q      <= sample.pressed;
					fired_q       <= 1'b0;
					press_start_q <= sample.pressed ? sample.now_ms : '0;
				end else if (pulse) begin
					fired_q <= 1'b1;
				end
			end
		end
	end

endmodule
